// ===== hw/rtl/u2c_pkg.sv =====
// u2c_pkg: shared types, constants and the code point map of the UTF-8 to
// Windows-1252 transcoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package u2c_pkg;

  localparam int unsigned BufDepth  = 4;
  localparam int unsigned CpWidth   = 21;
  localparam logic [7:0]  ReplByte  = 8'h3f;

  // Result of checking and decoding one complete sequence.
  typedef struct packed {
    logic       bad;       // a continuation byte has the wrong form
    logic [2:0] bad_pos;   // position of the first bad continuation
    logic [7:0] code;      // mapped byte when not bad
    logic       sub;       // code is a replacement
  } dec_t;

  // Code point to {substituted, byte}.
  function automatic logic [8:0] map_cp(input logic [CpWidth-1:0] cp);
    logic [8:0] res;
    if (cp <= 21'h7f || (cp >= 21'ha0 && cp <= 21'hff)) begin
      res = {1'b0, cp[7:0]};
    end else begin
      unique case (cp)
        21'h20ac: res = {1'b0, 8'h80};
        21'h201a: res = {1'b0, 8'h82};
        21'h0192: res = {1'b0, 8'h83};
        21'h201e: res = {1'b0, 8'h84};
        21'h2026: res = {1'b0, 8'h85};
        21'h2020: res = {1'b0, 8'h86};
        21'h2021: res = {1'b0, 8'h87};
        21'h02c6: res = {1'b0, 8'h88};
        21'h2030: res = {1'b0, 8'h89};
        21'h0160: res = {1'b0, 8'h8a};
        21'h2039: res = {1'b0, 8'h8b};
        21'h0152: res = {1'b0, 8'h8c};
        21'h017d: res = {1'b0, 8'h8e};
        21'h2018: res = {1'b0, 8'h91};
        21'h2019: res = {1'b0, 8'h92};
        21'h201c: res = {1'b0, 8'h93};
        21'h201d: res = {1'b0, 8'h94};
        21'h2022: res = {1'b0, 8'h95};
        21'h2013: res = {1'b0, 8'h96};
        21'h2014: res = {1'b0, 8'h97};
        21'h02dc: res = {1'b0, 8'h98};
        21'h2122: res = {1'b0, 8'h99};
        21'h0161: res = {1'b0, 8'h9a};
        21'h203a: res = {1'b0, 8'h9b};
        21'h0153: res = {1'b0, 8'h9c};
        21'h017e: res = {1'b0, 8'h9e};
        21'h0178: res = {1'b0, 8'h9f};
        default:  res = {1'b1, ReplByte};
      endcase
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/u2c_in_if.sv =====
// u2c_in_if: valid/ready channel carrying raw UTF-8 bytes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface u2c_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/u2c_out_if.sv =====
// u2c_out_if: valid/ready channel carrying Windows-1252 result bytes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface u2c_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       substituted;
  logic       run_end;
  logic       stream_end;

  modport source (output valid, output out_byte, output substituted,
                  output run_end, output stream_end, input ready);
  modport sink   (input valid, input out_byte, input substituted,
                  input run_end, input stream_end, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/u2c_seq_decode.sv =====
// u2c_seq_decode: checks a complete UTF-8 sequence and maps its code point.
// Depends on u2c_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u2c_seq_decode (
  input  wire logic [3:0][7:0]  seq_i,
  input  wire logic [2:0]       len_i,
  output u2c_pkg::dec_t         dec_o
);

  logic                          found;
  logic [2:0]                    pos;
  logic [u2c_pkg::CpWidth-1:0]   cp;
  logic [8:0]                    map;

  // first continuation that is not 10xxxxxx
  always_comb begin
    found = 1'b0;
    pos   = 3'd0;
    for (int i = 1; i < 4; i++) begin
      if (3'(i) < len_i && !found && seq_i[i][7:6] != 2'b10) begin
        found = 1'b1;
        pos   = 3'(i);
      end
    end
  end

  always_comb begin
    unique case (len_i)
      3'd2:    cp = {10'd0, seq_i[0][4:0], seq_i[1][5:0]};
      3'd3:    cp = {5'd0, seq_i[0][3:0], seq_i[1][5:0], seq_i[2][5:0]};
      default: cp = {seq_i[0][2:0], seq_i[1][5:0], seq_i[2][5:0], seq_i[3][5:0]};
    endcase
  end

  assign map = u2c_pkg::map_cp(cp);

  assign dec_o.bad     = found;
  assign dec_o.bad_pos = pos;
  assign dec_o.code    = map[7:0];
  assign dec_o.sub     = map[8];

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_to_cp1252_transcoder_unit.sv =====
// utf8_to_cp1252_transcoder_unit: UTF-8 byte stream in, Windows-1252 bytes out.
// Depends on u2c_pkg, u2c_in_if, u2c_out_if and u2c_seq_decode.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Fields                                        Transfer
// in_i      in   in_byte[7:0], in_last                         valid & ready
// out_o     out  out_byte[7:0], substituted, run_end, stream_end valid & ready
//
// One byte per transfer on in_i; ready is high only while the sequencer idles.
// Each byte taken goes through the byte step (the new byte plus any replayed
// ones), any extra '?' of a bad sequence, an early stream end and the run
// close before the sequencer idles again.
// Any cycle in which the output register is full and not taken stalls the step.
// Reset clears the sequencer, the byte counts and both valid flags.

module utf8_to_cp1252_transcoder_unit (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  u2c_in_if.sink      in_i,
  u2c_out_if.source   out_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WORK = 1'b1;

  logic state_q, state_d;

  // Byte store: the pending sequence (first k bytes) followed by the bytes
  // still to be fed (the new byte and any replayed ones), n bytes in all.
  logic [3:0][7:0] a_q, a_d;
  logic [2:0]      n_q, n_d;
  logic [1:0]      k_q, k_d;
  logic [2:0]      seq_len_q, seq_len_d;
  logic [1:0]      rep_cnt_q, rep_cnt_d;   // '?' still owed for a bad sequence
  logic            last_q, last_d;

  // One result is held back so that the last one of a run can be marked.
  logic            hold_v_q, hold_v_d;
  logic [7:0]      hold_byte_q, hold_byte_d;
  logic            hold_sub_q, hold_sub_d;

  logic            out_v_q, out_v_d;
  logic [7:0]      out_byte_q, out_byte_d;
  logic            out_sub_q, out_sub_d;
  logic            out_run_q, out_run_d;
  logic            out_strm_q, out_strm_d;

  logic            can_go;
  logic            step;
  logic            emit_v;
  logic [7:0]      emit_byte;
  logic            emit_sub;
  logic [2:0]      sh;
  logic [2:0]      src;
  logic [7:0]      cur;
  logic [2:0]      lead_len;
  logic            finish;
  u2c_pkg::dec_t   dec;

  u2c_seq_decode u_dec (
    .seq_i (a_q),
    .len_i (seq_len_q),
    .dec_o (dec)
  );

  assign can_go = !out_v_q || out_o.ready;
  assign step   = (state_q == ST_WORK) && can_go;
  assign cur    = a_q[k_q];

  // lead byte class: 0 = not a valid lead (ASCII handled apart)
  always_comb begin
    priority if (cur[7:5] == 3'b110) begin
      lead_len = 3'd2;
    end else if (cur[7:4] == 4'b1110) begin
      lead_len = 3'd3;
    end else if (cur[7:3] == 5'b11110) begin
      lead_len = 3'd4;
    end else begin
      lead_len = 3'd0;
    end
  end

  // Sequencer: byte step, '?', early end or run close per cycle if not stalled.
  always_comb begin
    state_d   = state_q;
    a_d       = a_q;
    n_d       = n_q;
    k_d       = k_q;
    seq_len_d = seq_len_q;
    rep_cnt_d = rep_cnt_q;
    last_d    = last_q;
    emit_v    = 1'b0;
    emit_byte = u2c_pkg::ReplByte;
    emit_sub  = 1'b1;
    sh        = 3'd0;
    src       = 3'd0;
    finish    = 1'b0;

    if (state_q == ST_IDLE) begin
      if (in_i.valid) begin
        a_d[n_q[1:0]] = in_i.in_byte;
        n_d           = n_q + 3'd1;
        last_d        = in_i.in_last;
        state_d       = ST_WORK;
      end
    end else if (step) begin
      priority if (rep_cnt_q != 2'd0) begin
        emit_v    = 1'b1;
        rep_cnt_d = rep_cnt_q - 2'd1;
      end else if ({1'b0, k_q} < n_q) begin
        if (seq_len_q == 3'd0) begin
          priority if (!cur[7]) begin
            emit_v    = 1'b1;
            emit_byte = cur;
            emit_sub  = 1'b0;
            sh        = 3'd1;
          end else if (lead_len != 3'd0) begin
            seq_len_d = lead_len;
            k_d       = 2'd1;
          end else begin
            emit_v = 1'b1;
            sh     = 3'd1;
          end
        end else if ({1'b0, k_q} + 3'd1 == seq_len_q) begin
          // sequence complete
          k_d       = 2'd0;
          seq_len_d = 3'd0;
          emit_v    = 1'b1;
          if (dec.bad) begin
            rep_cnt_d = 2'(dec.bad_pos - 3'd1);
            sh        = dec.bad_pos;
          end else begin
            emit_byte = dec.code;
            emit_sub  = dec.sub;
            sh        = seq_len_q;
          end
        end else begin
          k_d = k_q + 2'd1;
        end
      end else if (last_q && seq_len_q != 3'd0) begin
        // stream ended inside a sequence
        emit_v    = 1'b1;
        seq_len_d = 3'd0;
        k_d       = 2'd0;
        n_d       = 3'd0;
      end else begin
        finish  = 1'b1;
        state_d = ST_IDLE;
        if (last_q) begin
          n_d = 3'd0;
          k_d = 2'd0;
        end
      end

      if (sh != 3'd0) begin
        n_d = n_q - sh;
        for (int i = 0; i < 4; i++) begin
          src = 3'(i) + sh;
          if (src < 3'd4) begin
            a_d[i] = a_q[src[1:0]];
          end
        end
      end
    end
  end

  // hold and output registers
  always_comb begin
    hold_v_d    = hold_v_q;
    hold_byte_d = hold_byte_q;
    hold_sub_d  = hold_sub_q;
    out_v_d     = out_v_q && !out_o.ready;
    out_byte_d  = out_byte_q;
    out_sub_d   = out_sub_q;
    out_run_d   = out_run_q;
    out_strm_d  = out_strm_q;

    if (emit_v) begin
      if (hold_v_q) begin
        out_v_d    = 1'b1;
        out_byte_d = hold_byte_q;
        out_sub_d  = hold_sub_q;
        out_run_d  = 1'b0;
        out_strm_d = 1'b0;
      end
      hold_v_d    = 1'b1;
      hold_byte_d = emit_byte;
      hold_sub_d  = emit_sub;
    end else if (finish && hold_v_q) begin
      out_v_d    = 1'b1;
      out_byte_d = hold_byte_q;
      out_sub_d  = hold_sub_q;
      out_run_d  = 1'b1;
      out_strm_d = last_q;
      hold_v_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      n_q       <= 3'd0;
      k_q       <= 2'd0;
      seq_len_q <= 3'd0;
      rep_cnt_q <= 2'd0;
      last_q    <= 1'b0;
      hold_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      k_q       <= k_d;
      seq_len_q <= seq_len_d;
      rep_cnt_q <= rep_cnt_d;
      last_q    <= last_d;
      hold_v_q  <= hold_v_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q         <= a_d;
    hold_byte_q <= hold_byte_d;
    hold_sub_q  <= hold_sub_d;
    out_byte_q  <= out_byte_d;
    out_sub_q   <= out_sub_d;
    out_run_q   <= out_run_d;
    out_strm_q  <= out_strm_d;
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_v_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.substituted = out_sub_q;
  assign out_o.run_end     = out_run_q;
  assign out_o.stream_end  = out_strm_q;

  // the last result of a stream also closes its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_strm_q) |-> out_run_q)
    else $error("stream end without run end");

  // closing a final byte leaves nothing pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && last_q) |=> (seq_len_q == 3'd0 && n_q == 3'd0))
    else $error("state left after end of stream");

  // the pending sequence never runs past the stored bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, k_q} <= n_q) && (n_q <= 3'd4))
    else $error("byte counts out of range");

  // owed replacements only exist while an item is being worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rep_cnt_q != 2'd0) |-> (state_q == ST_WORK))
    else $error("replacements owed while idle");

endmodule

`default_nettype wire

// ===== bench/tb_utf8_to_cp1252_transcoder_unit.sv =====
// tb_utf8_to_cp1252_transcoder_unit: self-checking bench for the UTF-8 to
// Windows-1252 transcoder, with directed and random byte streams.
// Depends on u2c_pkg, u2c_in_if, u2c_out_if and utf8_to_cp1252_transcoder_unit.
`timescale 1ns / 1ps

module tb_utf8_to_cp1252_transcoder_unit;

  // Lead and continuation byte classes.
  localparam logic [7:0] ContMask  = 8'hc0;
  localparam logic [7:0] ContTag   = 8'h80;
  localparam logic [7:0] Lead2Tag  = 8'hc0;
  localparam logic [7:0] Lead3Tag  = 8'he0;
  localparam logic [7:0] Lead4Tag  = 8'hf0;
  localparam int         SettleCyc = 20;    // quiet cycles after the last result

  // One output transfer, in port order.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       substituted;
    logic       run_end;
    logic       stream_end;
  } cp1252_res_t;

  // {code point, Windows-1252 byte} for the 27 entries of the 80-9F block.
  logic [23:0] cp1252_map [27] = '{
    24'h20ac80, 24'h201a82, 24'h019283, 24'h201e84, 24'h202685, 24'h202086,
    24'h202187, 24'h02c688, 24'h203089, 24'h01608a, 24'h20398b, 24'h01528c,
    24'h017d8e, 24'h201891, 24'h201992, 24'h201c93, 24'h201d94, 24'h202295,
    24'h201396, 24'h201497, 24'h02dc98, 24'h212299, 24'h01619a, 24'h203a9b,
    24'h01539c, 24'h017e9e, 24'h01789f
  };

  logic clk_i;
  logic rst_ni;

  u2c_in_if  in_ch ();
  u2c_out_if out_ch ();

  utf8_to_cp1252_transcoder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // ---------------------------------------------------------------------------
  // Clock, reset and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The timeout leaves a wide margin over the worst case of the whole run.
  initial begin
    #(5_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Decoder state mirror and expected results
  // ---------------------------------------------------------------------------
  logic [7:0]  held_bytes [4];
  logic [2:0]  held_count;
  logic [2:0]  seq_len;          // 0: no sequence pending
  logic [7:0]  step_bytes [4];   // results of the byte being predicted
  logic        step_subs  [4];
  int          step_n;
  cp1252_res_t expected_out [$];
  int          fail_count;
  bit          steady_flow;      // when set, neither side idles
  logic [7:0]  stream_bytes [$]; // stream under construction

  function automatic void add_result(input logic [7:0] b, input logic sub);
    // A step never gives more than four bytes.
    if (step_n < 4) begin
      step_bytes[step_n] = b;
      step_subs[step_n]  = sub;
      step_n++;
    end
  endfunction

  function automatic void add_codepoint(input logic [20:0] cp);
    int i;
    if (cp <= 21'h7f || (cp >= 21'ha0 && cp <= 21'hff)) begin
      add_result(cp[7:0], 1'b0);
      return;
    end
    for (i = 0; i < 27; i++) begin
      if ({5'd0, cp1252_map[i][23:8]} == cp) begin
        add_result(cp1252_map[i][7:0], 1'b0);
        return;
      end
    end
    add_result(u2c_pkg::ReplByte, 1'b1);
  endfunction

  // Runs one byte through the sequencer. A bad continuation pushes the held
  // tail back to the front of the work list, so replays go depth first.
  function automatic void absorb_byte(input logic [7:0] first);
    logic [7:0]  work_b [$];
    int          work_d [$];
    logic [7:0]  b;
    int          d;
    int          len;
    int          bad;
    int          i;
    logic [20:0] cp;
    work_b.push_back(first);
    work_d.push_back(0);
    while (work_b.size() > 0) begin
      b = work_b.pop_front();
      d = work_d.pop_front();
      if (d > 8) continue;
      if (seq_len == 3'd0) begin
        if (b < ContTag) begin
          add_result(b, 1'b0);
        end else if ((b & 8'he0) == Lead2Tag) begin
          held_bytes[0] = b; held_count = 3'd1; seq_len = 3'd2;
        end else if ((b & 8'hf0) == Lead3Tag) begin
          held_bytes[0] = b; held_count = 3'd1; seq_len = 3'd3;
        end else if ((b & 8'hf8) == Lead4Tag) begin
          held_bytes[0] = b; held_count = 3'd1; seq_len = 3'd4;
        end else begin
          add_result(u2c_pkg::ReplByte, 1'b1);       // stray continuation or F8-FF
        end
        continue;
      end
      if (held_count < 3'd4) held_bytes[held_count[1:0]] = b;
      held_count++;
      if (held_count < seq_len) continue;

      len        = (seq_len > 3'd4) ? 4 : int'(seq_len);
      held_count = 3'd0;
      seq_len    = 3'd0;
      bad        = 0;
      for (i = 1; i < len; i++) begin
        if (bad == 0 && (held_bytes[i] & ContMask) != ContTag) bad = i;
      end
      if (bad == 0) begin
        if (len == 2)      cp = {16'd0, held_bytes[0][4:0]};
        else if (len == 3) cp = {17'd0, held_bytes[0][3:0]};
        else               cp = {18'd0, held_bytes[0][2:0]};
        for (i = 1; i < len; i++) cp = {cp[14:0], held_bytes[i][5:0]};
        add_codepoint(cp);
      end else begin
        for (i = 0; i < bad; i++) add_result(u2c_pkg::ReplByte, 1'b1);
        for (i = len - 1; i >= bad; i--) begin
          work_b.push_front(held_bytes[i]);
          work_d.push_front(d + 1);
        end
      end
    end
  endfunction

  function automatic void predict_transfer(input logic [7:0] b, input logic last);
    int k;
    cp1252_res_t r;
    step_n = 0;
    absorb_byte(b);
    if (last) begin
      if (seq_len != 3'd0) add_result(u2c_pkg::ReplByte, 1'b1);   // stream cut short
      held_count = 3'd0;
      seq_len    = 3'd0;
    end
    for (k = 0; k < step_n; k++) begin
      r.out_byte    = step_bytes[k];
      r.substituted = step_subs[k];
      r.run_end     = (k == step_n - 1);
      r.stream_end  = (k == step_n - 1) && last;
      expected_out.push_back(r);
    end
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  function automatic int draw_wait();
    if (steady_flow) return 0;
    return $urandom_range(0, 8);
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random backpressure and result checking
  // ---------------------------------------------------------------------------
  initial begin : result_pacer
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
    end
  end

  always @(posedge clk_i) begin : result_check
    cp1252_res_t got;
    cp1252_res_t want;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = {out_ch.out_byte, out_ch.substituted, out_ch.run_end, out_ch.stream_end};
      if (expected_out.size() == 0) begin
        note_failure($sformatf("%0t: unexpected result byte=%02h sub=%b run=%b end=%b",
                               $realtime, got.out_byte, got.substituted, got.run_end,
                               got.stream_end));
      end else begin
        want = expected_out.pop_front();
        if (got !== want)
          note_failure($sformatf({"%0t: mismatch exp byte=%02h sub=%b run=%b end=%b",
                                  " got byte=%02h sub=%b run=%b end=%b"},
                                 $realtime, want.out_byte, want.substituted,
                                 want.run_end, want.stream_end, got.out_byte,
                                 got.substituted, got.run_end, got.stream_end));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Called at a rising edge. Valid stays high from one transfer to the next
  // when no gap is drawn, so it is never lowered and raised in one step.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    predict_transfer(b, last);
  endtask

  // Stop sending until every predicted byte has come out.
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_out.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_cont();
    return 8'($urandom_range(8'h80, 8'hbf));
  endfunction

  function automatic void put_codepoint(input logic [20:0] cp);
    if (cp <= 21'h7ff) begin
      stream_bytes.push_back({3'b110, cp[10:6]});
    end else begin
      stream_bytes.push_back({4'b1110, cp[15:12]});
      stream_bytes.push_back({2'b10, cp[11:6]});
    end
    stream_bytes.push_back({2'b10, cp[5:0]});
  endfunction

  function automatic logic [7:0] rand_lead(input int len);
    if (len == 2) return 8'($urandom_range(8'hc0, 8'hdf));
    if (len == 3) return 8'($urandom_range(8'he0, 8'hef));
    return 8'($urandom_range(8'hf0, 8'hf7));
  endfunction

  // Appends one randomly chosen character or fault to the stream.
  function automatic void put_token(input bit cut_short);
    int kind;
    int len;
    int good;
    int i;
    kind = $urandom_range(0, 99);
    if (cut_short) begin
      // lead with too few continuations, stream ends on it
      len = $urandom_range(2, 4);
      stream_bytes.push_back(rand_lead(len));
      good = $urandom_range(0, len - 2);
      for (i = 0; i < good; i++) stream_bytes.push_back(rand_cont());
    end else if (kind < 28) begin
      stream_bytes.push_back(8'($urandom_range(0, 8'h7f)));
    end else if (kind < 43) begin
      put_codepoint(21'($urandom_range(8'h80, 8'hff)));
    end else if (kind < 60) begin
      put_codepoint({5'd0, cp1252_map[$urandom_range(0, 26)][23:8]});
    end else if (kind < 72) begin
      // well-formed shape, arbitrary payload bits (overlongs included)
      len = $urandom_range(2, 4);
      stream_bytes.push_back(rand_lead(len));
      for (i = 1; i < len; i++) stream_bytes.push_back(rand_cont());
    end else if (kind < 85) begin
      // broken sequence: some good continuations, then a non-continuation
      len = $urandom_range(2, 4);
      stream_bytes.push_back(rand_lead(len));
      good = $urandom_range(0, len - 2);
      for (i = 0; i < good; i++) stream_bytes.push_back(rand_cont());
      if ($urandom_range(0, 1) == 0)
        stream_bytes.push_back(8'($urandom_range(0, 8'h7f)));
      else
        stream_bytes.push_back(8'($urandom_range(8'hc0, 8'hff)));
    end else begin
      stream_bytes.push_back(8'($urandom_range(0, 8'hff)));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // ASCII extremes, a literal '?', and lead bytes that can never start a
  // sequence (stray continuations and F8-FF).
  task automatic test_single_bytes();
    steady_flow = 1'b1;
    send_byte(8'h00, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h3f, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'hbf, 1'b0);
    send_byte(8'hf8, 1'b0);
    send_byte(8'hff, 1'b1);
    steady_flow = 1'b0;
  endtask

  // Well-formed sequences: table entry, Latin-1 passthrough, an unmapped
  // C1 control, a code point past FF, and an overlong ASCII form.
  task automatic test_mapped_sequences();
    send_byte(8'he2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'hac, 1'b0);
    send_byte(8'hc3, 1'b0); send_byte(8'hbf, 1'b0);
    send_byte(8'hc2, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hf0, 1'b0); send_byte(8'h9f, 1'b0);
    send_byte(8'h98, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hc1, 1'b0); send_byte(8'h81, 1'b1);
  endtask

  // Bad continuation with replay of the tail, and a stream cut short.
  task automatic test_malformed_input();
    send_byte(8'he2, 1'b0); send_byte(8'h82, 1'b0); send_byte(8'h41, 1'b0);
    send_byte(8'hc3, 1'b1);
  endtask

  // Streams of random characters and faults. Streams mostly end with the
  // last flag; some run on into the next. One drain pause halfway.
  task automatic test_random_streams();
    int  sent;
    int  tokens;
    int  i;
    bit  paused;
    bit  closes;
    sent   = 0;
    paused = 1'b0;
    while (sent < 235) begin
      steady_flow = ($urandom_range(0, 4) == 0);
      stream_bytes.delete();
      tokens = $urandom_range(1, 8);
      for (i = 0; i < tokens; i++) put_token(1'b0);
      closes = ($urandom_range(0, 5) != 0);
      if (closes && $urandom_range(0, 3) == 0) put_token(1'b1);
      for (i = 0; i < stream_bytes.size(); i++)
        send_byte(stream_bytes[i], closes && (i == stream_bytes.size() - 1));
      sent += stream_bytes.size();
      if (!paused && sent >= 120) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end
    steady_flow = 1'b0;
    send_byte(8'h2e, 1'b1);   // close any open stream
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    fail_count    = 0;
    steady_flow   = 1'b0;
    held_count    = 3'd0;
    seq_len       = 3'd0;
    rst_ni        <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= 8'h00;
    in_ch.in_last <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_bytes();
    test_mapped_sequences();
    test_malformed_input();
    test_random_streams();

    hold_until_drained();
    repeat (SettleCyc) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
